@@ hw/rtl/assert_macros.svh @@
// Assertion helpers; checks compile away under SYNTHESIS.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

`define ASSERT_ALWAYS(lbl, expr) \
  lbl: assert property (@(posedge clk) disable iff (rst) (expr)) \
    else $error("assertion failed");

`define ASSERT_IMPLY(lbl, pre, post) \
  lbl: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) \
    else $error("assertion failed");

`define ASSERT_NEXT(lbl, pre, post) \
  lbl: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) \
    else $error("assertion failed");

`else

`define ASSERT_ALWAYS(lbl, expr)
`define ASSERT_IMPLY(lbl, pre, post)
`define ASSERT_NEXT(lbl, pre, post)

`endif

`endif

@@ hw/rtl/cdbr_pkg.sv @@
package cdbr_pkg;

  localparam int PIX_W  = 8;
  localparam int COL_W  = 6;
  localparam int FREQ_W = 20;
  localparam int HALF_W = 16;
  localparam int NUM_W  = 26;

  localparam logic [7:0] CODE_SPACE   = 8'd32;
  localparam logic [7:0] CODE_SOLID   = 8'd3;
  localparam logic [7:0] CODE_PARTIAL = 8'd7;

  localparam logic [FREQ_W-1:0] TARGET_RST = 20'd50000;
  localparam logic [HALF_W-1:0] HALF_RST   = 16'd200;

  localparam logic REG_TARGET = 1'b0;
  localparam logic REG_HALF   = 1'b1;

  localparam int QDEPTH = 2;

  typedef enum logic [2:0] {
    F_IDLE,
    F_MUL,
    F_DIV,
    F_CLS,
    F_PUSH
  } front_state_t;

  typedef struct packed {
    logic [PIX_W-1:0] pixel;
    logic             right;
    logic [4:0]       full;
    logic [2:0]       rem;
    logic [4:0]       mask;
    logic             upd;
  } bar_entry_t;

  function automatic logic [4:0] fill_mask(input logic [2:0] rem, input logic right);
    logic [4:0] m;
    m = '0;
    for (int i = 0; i < 5; i++) begin
      if (3'(i) < rem) begin
        if (right) begin
          m[4-i] = 1'b1;
        end else begin
          m[i] = 1'b1;
        end
      end
    end
    return m;
  endfunction

endpackage

@@ hw/rtl/cdbr_front.sv @@
module cdbr_front #(
  parameter int COLUMNS = 20
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          push,
  output logic                          full,
  input  logic [cdbr_pkg::FREQ_W-1:0]   freq_mhz,
  input  logic [cdbr_pkg::FREQ_W-1:0]   target_mhz,
  input  logic [cdbr_pkg::HALF_W-1:0]   half_range_mhz,
  output logic                          q_push,
  input  logic                          q_full,
  output cdbr_pkg::bar_entry_t          q_data
);
  import cdbr_pkg::*;

  localparam int PIXELS = 5 * COLUMNS;
  localparam logic [PIX_W-1:0] PIX_M1 = PIX_W'(PIXELS - 1);
  localparam logic [PIX_W-1:0] CENTER = PIX_W'(PIXELS / 2);

  front_state_t state, state_next;

  logic [16:0]       d;
  logic [HALF_W-1:0] h;
  logic              zero_h;
  logic [NUM_W-1:0]  num;
  logic [NUM_W-1:0]  dsh;
  logic [2:0]        bitc;
  logic [PIX_W-1:0]  quo;
  bar_entry_t        entry;

  logic signed [21:0] lo;
  logic [20:0]        hi;
  logic [16:0]        d_in;
  logic               accept;
  logic               ge;

  logic [PIX_W-1:0] pix;
  logic             right;
  logic [PIX_W-1:0] adist;
  logic [15:0]      prod;
  logic [4:0]       fullc;
  logic [PIX_W-1:0] rem_w;

  assign accept = push && !full;

  always_comb begin
    lo = $signed({2'b00, target_mhz}) - $signed({6'd0, half_range_mhz});
    hi = {1'b0, target_mhz} + {5'd0, half_range_mhz};
    if ($signed({2'b00, freq_mhz}) < lo) begin
      d_in = '0;
    end else if ({1'b0, freq_mhz} > hi) begin
      d_in = {half_range_mhz, 1'b0};
    end else begin
      d_in = 17'($signed({2'b00, freq_mhz}) - lo);
    end
  end

  assign ge = num >= dsh;

  always_comb begin
    pix   = zero_h ? CENTER : quo;
    right = pix > CENTER;
    adist = right ? (pix - CENTER) : (CENTER - pix);
    prod  = {8'd0, adist} * 16'd205;
    fullc = prod[14:10];
    rem_w = adist - PIX_W'({3'd0, fullc} * 8'd5);
  end

  always_comb begin
    state_next = state;
    case (state)
      F_IDLE: if (accept) state_next = F_MUL;
      F_MUL:  state_next = F_DIV;
      F_DIV:  if (bitc == 3'd0) state_next = F_CLS;
      F_CLS:  state_next = F_PUSH;
      F_PUSH: if (!q_full) state_next = F_IDLE;
      default: state_next = F_IDLE;
    endcase
  end

  always_comb begin
    full   = 1'b1;
    q_push = 1'b0;
    case (state)
      F_IDLE: full = 1'b0;
      F_PUSH: q_push = !q_full;
      default: begin
        full   = 1'b1;
        q_push = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= F_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    case (state)
      F_IDLE: begin
        d      <= d_in;
        h      <= half_range_mhz;
        zero_h <= (half_range_mhz == '0);
      end
      F_MUL: begin
        num  <= ({9'd0, d} * {18'd0, PIX_M1}) + {10'd0, h};
        dsh  <= {2'b00, h, 8'd0};
        bitc <= 3'd7;
      end
      F_DIV: begin
        if (ge) begin
          num <= num - dsh;
        end
        quo  <= {quo[PIX_W-2:0], ge};
        dsh  <= dsh >> 1;
        bitc <= bitc - 3'd1;
      end
      F_CLS: begin
        entry.pixel <= pix;
        entry.right <= right;
        entry.full  <= fullc;
        entry.rem   <= rem_w[2:0];
        entry.mask  <= fill_mask(rem_w[2:0], right);
        entry.upd   <= (rem_w[2:0] != 3'd0);
      end
      default: begin
        entry <= entry;
      end
    endcase
  end

  assign q_data = entry;

endmodule

@@ hw/rtl/cdbr_queue.sv @@
module cdbr_queue (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 wr_en,
  input  cdbr_pkg::bar_entry_t wr_data,
  output logic                 q_full,
  input  logic                 rd_en,
  output cdbr_pkg::bar_entry_t rd_data,
  output logic                 q_empty
);
  import cdbr_pkg::*;

  localparam int PTR_W = $clog2(QDEPTH);

  bar_entry_t         slots [QDEPTH];
  logic [PTR_W-1:0]   wr_ptr;
  logic [PTR_W-1:0]   rd_ptr;
  logic [PTR_W:0]     count;

  assign q_full  = (count == (PTR_W+1)'(QDEPTH));
  assign q_empty = (count == '0);
  assign rd_data = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (wr_en && !q_full) begin
      slots[wr_ptr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (wr_en && !q_full) begin
        wr_ptr <= (wr_ptr == PTR_W'(QDEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (rd_en && !q_empty) begin
        rd_ptr <= (rd_ptr == PTR_W'(QDEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      count <= count + (PTR_W+1)'(wr_en && !q_full) - (PTR_W+1)'(rd_en && !q_empty);
    end
  end

endmodule

@@ hw/rtl/cdbr_back.sv @@
module cdbr_back #(
  parameter int COLUMNS = 20
) (
  input  logic                       clk,
  input  logic                       rst,
  input  cdbr_pkg::bar_entry_t       q_data,
  input  logic                       q_empty,
  output logic                       q_pop,
  input  logic                       pop,
  output logic                       empty,
  output logic [cdbr_pkg::COL_W-1:0] column,
  output logic [7:0]                 char_code,
  output logic [4:0]                 glyph_mask,
  output logic                       glyph_update,
  output logic [cdbr_pkg::PIX_W-1:0] bar_pixel,
  output logic                       last
);
  import cdbr_pkg::*;

  localparam logic [COL_W-1:0] CCOL  = COL_W'(COLUMNS / 2);
  localparam logic [COL_W-1:0] LASTC = COL_W'(COLUMNS - 1);

  logic [COL_W-1:0] col;
  logic             out_valid;
  logic             adv;
  logic             on_side;
  logic [COL_W-1:0] offs;
  logic [7:0]       code;

  assign empty = !out_valid;
  assign adv   = !q_empty && (!out_valid || pop);
  assign q_pop = adv && (col == LASTC);

  always_comb begin
    if (q_data.right) begin
      on_side = col > CCOL;
      offs    = col - CCOL;
    end else begin
      on_side = col < CCOL;
      offs    = CCOL - col;
    end
    if (col == CCOL) begin
      code = CODE_SOLID;
    end else if (on_side && offs <= {1'b0, q_data.full}) begin
      code = CODE_SOLID;
    end else if (on_side && q_data.upd && offs == ({1'b0, q_data.full} + 6'd1)) begin
      code = CODE_PARTIAL;
    end else begin
      code = CODE_SPACE;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      col       <= '0;
      out_valid <= 1'b0;
    end else begin
      if (adv) begin
        col       <= (col == LASTC) ? '0 : col + COL_W'(1);
        out_valid <= 1'b1;
      end else if (pop) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      column       <= col;
      char_code    <= code;
      glyph_mask   <= q_data.mask;
      glyph_update <= q_data.upd;
      bar_pixel    <= q_data.pixel;
      last         <= (col == LASTC);
    end
  end

endmodule

@@ hw/rtl/centered_deviation_bar_renderer.sv @@
// Deviation bar for one character-LCD row. Each frequency sample (mHz) is
// clamped to target_mhz +/- half_range_mhz, mapped with round-half-up to a
// pixel in 0..5*COLUMNS-1, and rendered as COLUMNS characters in column
// order, one per result, with last set on the final column. The front end
// takes one sample at a time (accept, one multiply, an 8-step shift-subtract
// divider, classify, hand-off, held while the queue is full) and runs ahead
// of the renderer through a two-entry queue; the renderer emits one character
// per cycle while the queue holds a sample and its output is empty or popped.
// The user must write registers only with no sample in flight; not enforced.
`include "assert_macros.svh"

module centered_deviation_bar_renderer #(
  parameter int COLUMNS = 20
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        cfg_we,
  input  logic                        cfg_index,
  input  logic [cdbr_pkg::FREQ_W-1:0] cfg_data,
  input  logic                        push,
  output logic                        full,
  input  logic [cdbr_pkg::FREQ_W-1:0] freq_mhz,
  input  logic                        pop,
  output logic                        empty,
  output logic [cdbr_pkg::COL_W-1:0]  column,
  output logic [7:0]                  char_code,
  output logic [4:0]                  glyph_mask,
  output logic                        glyph_update,
  output logic [cdbr_pkg::PIX_W-1:0]  bar_pixel,
  output logic                        last
);
  import cdbr_pkg::*;

  logic [FREQ_W-1:0] target_mhz;
  logic [HALF_W-1:0] half_range_mhz;
  logic              q_push;
  logic              q_full;
  logic              q_pop;
  logic              q_empty;
  bar_entry_t        q_wdata;
  bar_entry_t        q_rdata;

  always_ff @(posedge clk) begin
    if (rst) begin
      target_mhz     <= TARGET_RST;
      half_range_mhz <= HALF_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_TARGET: target_mhz     <= cfg_data;
        REG_HALF:   half_range_mhz <= cfg_data[HALF_W-1:0];
        default:    target_mhz     <= target_mhz;
      endcase
    end
  end

  cdbr_front #(.COLUMNS(COLUMNS)) u_front (
    .clk            (clk),
    .rst            (rst),
    .push           (push),
    .full           (full),
    .freq_mhz       (freq_mhz),
    .target_mhz     (target_mhz),
    .half_range_mhz (half_range_mhz),
    .q_push         (q_push),
    .q_full         (q_full),
    .q_data         (q_wdata)
  );

  cdbr_queue u_queue (
    .clk     (clk),
    .rst     (rst),
    .wr_en   (q_push),
    .wr_data (q_wdata),
    .q_full  (q_full),
    .rd_en   (q_pop),
    .rd_data (q_rdata),
    .q_empty (q_empty)
  );

  cdbr_back #(.COLUMNS(COLUMNS)) u_back (
    .clk          (clk),
    .rst          (rst),
    .q_data       (q_rdata),
    .q_empty      (q_empty),
    .q_pop        (q_pop),
    .pop          (pop),
    .empty        (empty),
    .column       (column),
    .char_code    (char_code),
    .glyph_mask   (glyph_mask),
    .glyph_update (glyph_update),
    .bar_pixel    (bar_pixel),
    .last         (last)
  );

  `ASSERT_IMPLY(a_last_col, !empty && last, column == COL_W'(COLUMNS - 1))
  `ASSERT_IMPLY(a_partial_upd, !empty && char_code == CODE_PARTIAL, glyph_update)
  `ASSERT_IMPLY(a_mask_upd, !empty && !glyph_update, glyph_mask == 5'd0)
  `ASSERT_NEXT(a_busy_after_push, push && !full, full)

endmodule
